### rtl/prst_pkg.sv
// ----------------------------------------------------------------------------
// prst_pkg
// Shared types and constants for the priority-sorted rule table.
// ----------------------------------------------------------------------------
package prst_pkg;

  localparam int ID_W    = 14;
  localparam int PRIO_W  = 16;
  localparam int IP_W    = 32;
  localparam int OPT_W   = 40;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUT,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [IP_W-1:0]   src_addr;
    logic [IP_W-1:0]   src_mask;
    logic [IP_W-1:0]   dst_addr;
    logic [IP_W-1:0]   dst_mask;
    logic [OPT_W-1:0]  options;
  } rule_t;

endpackage

### rtl/prst_if.sv
// ----------------------------------------------------------------------------
// prst_if
// Request and response channels of the rule table (valid/ready).
// ----------------------------------------------------------------------------
interface prst_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [prst_pkg::ID_W-1:0]   target_id;
  logic [prst_pkg::ID_W-1:0]   new_id;
  logic [prst_pkg::PRIO_W-1:0] rule_priority;
  logic [prst_pkg::IP_W-1:0]   src_address;
  logic [prst_pkg::IP_W-1:0]   src_netmask;
  logic [prst_pkg::IP_W-1:0]   dst_address;
  logic [prst_pkg::IP_W-1:0]   dst_netmask;
  logic [prst_pkg::OPT_W-1:0]  rule_options;
  logic [prst_pkg::SLOT_W-1:0] read_slot;

  modport source (
    output valid, kind, target_id, new_id, rule_priority, src_address,
           src_netmask, dst_address, dst_netmask, rule_options, read_slot,
    input  ready
  );
  modport sink (
    input  valid, kind, target_id, new_id, rule_priority, src_address,
           src_netmask, dst_address, dst_netmask, rule_options, read_slot,
    output ready
  );
endinterface

interface prst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic                         entry_valid;
  logic [prst_pkg::ID_W-1:0]    out_id;
  logic [prst_pkg::PRIO_W-1:0]  out_priority;
  logic [prst_pkg::IP_W-1:0]    out_src_address;
  logic [prst_pkg::IP_W-1:0]    out_src_netmask;
  logic [prst_pkg::IP_W-1:0]    out_dst_address;
  logic [prst_pkg::IP_W-1:0]    out_dst_netmask;
  logic [prst_pkg::OPT_W-1:0]   out_options;
  logic [prst_pkg::COUNT_W-1:0] rule_count;

  modport source (
    output valid, status, entry_valid, out_id, out_priority, out_src_address,
           out_src_netmask, out_dst_address, out_dst_netmask, out_options,
           rule_count,
    input  ready
  );
  modport sink (
    input  valid, status, entry_valid, out_id, out_priority, out_src_address,
           out_src_netmask, out_dst_address, out_dst_netmask, out_options,
           rule_count,
    output ready
  );
endinterface

### rtl/prst_rule_mem.sv
// ----------------------------------------------------------------------------
// prst_rule_mem
// Rule storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prst_rule_mem #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  prst_pkg::rule_t       wr_rule,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output prst_pkg::rule_t       rd_rule
);

  prst_pkg::rule_t rule_mem_r [TABLE_DEPTH];
  prst_pkg::rule_t rd_rule_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem_r[wr_addr] <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rule_r <= rule_mem_r[rd_addr];
    end
  end

  assign rd_rule = rd_rule_r;

endmodule

### rtl/prst_seq.sv
// ----------------------------------------------------------------------------
// prst_seq
// Request sequencer: scans, shifts and writes the rule memory, holds the
// rule count and the response register.
// ----------------------------------------------------------------------------
module prst_seq #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  prst_req_if.sink         req,
  prst_rsp_if.source       rsp,
  output logic             mem_wr_en,
  output logic [AW-1:0]    mem_wr_addr,
  output prst_pkg::rule_t  mem_wr_rule,
  output logic             mem_rd_en,
  output logic [AW-1:0]    mem_rd_addr,
  input  prst_pkg::rule_t  mem_rd_rule
);

  localparam int XW = (CW > prst_pkg::SLOT_W) ? CW : prst_pkg::SLOT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  prst_pkg::state_t  state_r, state_nxt;
  prst_pkg::kind_t   kind_r, kind_nxt;
  logic [prst_pkg::ID_W-1:0] target_r, target_nxt;
  prst_pkg::rule_t   new_r, new_nxt;
  prst_pkg::rule_t   res_r, res_nxt;
  prst_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     ra_r, ra_nxt;
  logic              rv_r, rv_nxt;

  logic              out_valid_r, out_valid_nxt;
  prst_pkg::status_t out_status_r, out_status_nxt;
  logic              out_ev_r, out_ev_nxt;
  prst_pkg::rule_t   out_rule_r, out_rule_nxt;
  logic [prst_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic              accept;
  prst_pkg::kind_t   in_kind;
  logic [XW-1:0]     slot_x;
  logic              slot_empty;
  logic              table_full;
  logic              hit;
  logic              scan_more;
  logic              scan_miss;
  logic              out_free;
  logic [CW-1:0]     rd_idx;
  logic [CW-1:0]     wr_idx;

  assign req.ready  = (state_r == prst_pkg::ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign in_kind    = prst_pkg::kind_t'(req.kind);
  assign slot_x     = XW'(req.read_slot);
  assign slot_empty = slot_x >= XW'(cnt_r);
  assign table_full = (cnt_r == DEPTH_C);
  assign hit        = rv_r && ((kind_r == prst_pkg::KIND_INSERT) ?
                               (mem_rd_rule.prio > new_r.prio) :
                               (mem_rd_rule.id == target_r));
  assign scan_more  = !hit && (idx_r < cnt_r);
  assign scan_miss  = !rv_r && !(idx_r < cnt_r);
  assign out_free   = !out_valid_r || rsp.ready;

  assign mem_rd_addr = rd_idx[AW-1:0];
  assign mem_wr_addr = wr_idx[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prst_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            prst_pkg::KIND_INSERT: state_nxt = table_full ? prst_pkg::ST_DONE
                                                          : prst_pkg::ST_SCAN;
            prst_pkg::KIND_READ:   state_nxt = slot_empty ? prst_pkg::ST_DONE
                                                          : prst_pkg::ST_FETCH;
            default:               state_nxt = prst_pkg::ST_SCAN;
          endcase
        end
      end
      prst_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = (kind_r == prst_pkg::KIND_UPDATE) ? prst_pkg::ST_PUT
                                                        : prst_pkg::ST_SHIFT;
        end else if (scan_miss) begin
          state_nxt = (kind_r == prst_pkg::KIND_INSERT) ? prst_pkg::ST_SHIFT
                                                        : prst_pkg::ST_DONE;
        end
      end
      prst_pkg::ST_SHIFT: begin
        if (kind_r == prst_pkg::KIND_INSERT) begin
          if (idx_r == pos_r) state_nxt = prst_pkg::ST_PUT;
        end else begin
          if (idx_r == cnt_r) state_nxt = prst_pkg::ST_DONE;
        end
      end
      prst_pkg::ST_PUT:   state_nxt = prst_pkg::ST_DONE;
      prst_pkg::ST_FETCH: state_nxt = prst_pkg::ST_DONE;
      prst_pkg::ST_DONE: begin
        if (out_free) state_nxt = prst_pkg::ST_IDLE;
      end
      default: state_nxt = prst_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_nxt       = kind_r;
    target_nxt     = target_r;
    new_nxt        = new_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    mem_rd_en      = 1'b0;
    rd_idx         = idx_r;
    mem_wr_en      = 1'b0;
    wr_idx         = pos_r;
    mem_wr_rule    = new_r;
    out_valid_nxt  = out_valid_r && !rsp.ready;
    out_status_nxt = out_status_r;
    out_ev_nxt     = out_ev_r;
    out_rule_nxt   = out_rule_r;
    out_cnt_nxt    = out_cnt_r;

    case (state_r)
      prst_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt         = in_kind;
          target_nxt       = req.target_id;
          new_nxt.id       = req.new_id;
          new_nxt.prio     = req.rule_priority;
          new_nxt.src_addr = req.src_address;
          new_nxt.src_mask = req.src_netmask;
          new_nxt.dst_addr = req.dst_address;
          new_nxt.dst_mask = req.dst_netmask;
          new_nxt.options  = req.rule_options;
          idx_nxt          = '0;
          status_nxt       = prst_pkg::STAT_OK;
          if (in_kind == prst_pkg::KIND_INSERT && table_full) begin
            status_nxt = prst_pkg::STAT_FULL;
          end
          if (in_kind == prst_pkg::KIND_READ) begin
            if (slot_empty) begin
              status_nxt = prst_pkg::STAT_EMPTY;
            end else begin
              mem_rd_en = 1'b1;
              rd_idx    = CW'(slot_x);
            end
          end
        end
      end
      prst_pkg::ST_SCAN: begin
        if (scan_more) begin
          mem_rd_en = 1'b1;
          rd_idx    = idx_r;
          idx_nxt   = idx_r + 1'b1;
        end
        if (hit) begin
          pos_nxt = ra_r;
          if (kind_r == prst_pkg::KIND_INSERT) begin
            idx_nxt = cnt_r;
          end else begin
            idx_nxt = ra_r + 1'b1;
          end
        end else if (scan_miss) begin
          if (kind_r == prst_pkg::KIND_INSERT) begin
            pos_nxt = cnt_r;
            idx_nxt = cnt_r;
          end else begin
            status_nxt = prst_pkg::STAT_NOT_FOUND;
          end
        end
      end
      prst_pkg::ST_SHIFT: begin
        mem_wr_rule = mem_rd_rule;
        mem_wr_en   = rv_r;
        if (kind_r == prst_pkg::KIND_INSERT) begin
          wr_idx = ra_r + 1'b1;
          if (idx_r != pos_r) begin
            mem_rd_en = 1'b1;
            rd_idx    = idx_r - 1'b1;
            idx_nxt   = idx_r - 1'b1;
          end
        end else begin
          wr_idx = ra_r - 1'b1;
          if (idx_r != cnt_r) begin
            mem_rd_en = 1'b1;
            rd_idx    = idx_r;
            idx_nxt   = idx_r + 1'b1;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      prst_pkg::ST_PUT: begin
        mem_wr_en = 1'b1;
        wr_idx    = pos_r;
        if (kind_r == prst_pkg::KIND_INSERT) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      prst_pkg::ST_FETCH: begin
        res_nxt = mem_rd_rule;
      end
      prst_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_ev_nxt     = (kind_r == prst_pkg::KIND_READ) &&
                           (status_r == prst_pkg::STAT_OK);
          out_rule_nxt   = out_ev_nxt ? res_r : '0;
          out_cnt_nxt    = prst_pkg::COUNT_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  assign rv_nxt = mem_rd_en;
  assign ra_nxt = rd_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prst_pkg::ST_IDLE;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    target_r     <= target_nxt;
    new_r        <= new_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    ra_r         <= ra_nxt;
    out_status_r <= out_status_nxt;
    out_ev_r     <= out_ev_nxt;
    out_rule_r   <= out_rule_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign rsp.valid           = out_valid_r;
  assign rsp.status          = out_status_r;
  assign rsp.entry_valid     = out_ev_r;
  assign rsp.out_id          = out_rule_r.id;
  assign rsp.out_priority    = out_rule_r.prio;
  assign rsp.out_src_address = out_rule_r.src_addr;
  assign rsp.out_src_netmask = out_rule_r.src_mask;
  assign rsp.out_dst_address = out_rule_r.dst_addr;
  assign rsp.out_dst_netmask = out_rule_r.dst_mask;
  assign rsp.out_options     = out_rule_r.options;
  assign rsp.rule_count      = out_cnt_r;

endmodule

### rtl/priority_sorted_rule_table_core.sv
// ----------------------------------------------------------------------------
// priority_sorted_rule_table_core
// Rule table sorted by ascending priority on insert; update does not re-sort.
// ----------------------------------------------------------------------------
// in_req carries one request: insert, delete by id, update by id or read
// of a table position. out_rsp returns exactly one response per request
// with status, the rule read (reads only) and the rule count afterwards.
// Both channels use valid/ready; a request is taken only while the
// sequencer is idle, one at a time.
// Steps from acceptance to the response register:
//   read            fetch the slot
//   update          scan up to the match, one write
//   delete          scan up to the match, shift the rest down
//   insert          scan for the first higher priority, shift up, write
//   id miss         scan all rules; no memory writes
//   full/empty slot no memory writes
// The sequencer is idle again once the response is registered. Scan and
// shift are bound by the rule memory's single read and single write
// port: one entry is moved per cycle.
// Reset clears the rule count and the response valid flag; no memory
// clearing is needed. A stalled out_rsp holds its response; the next
// request is taken once that response is parked in the output register.
// ----------------------------------------------------------------------------
module priority_sorted_rule_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  prst_req_if.sink    in_req,
  prst_rsp_if.source  out_rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  prst_pkg::rule_t mem_wr_rule;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  prst_pkg::rule_t mem_rd_rule;

  prst_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_req),
    .rsp         (out_rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_rule (mem_wr_rule),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_rule (mem_rd_rule)
  );

  prst_rule_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_rule (mem_wr_rule),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_rule (mem_rd_rule)
  );

endmodule

### rtl/prst_chk.sv
// ----------------------------------------------------------------------------
// prst_chk
// Port-level checks for the rule table, bound to the top level.
// ----------------------------------------------------------------------------
module prst_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic                         out_entry_valid,
  input logic [prst_pkg::ID_W-1:0]    out_id,
  input logic [prst_pkg::PRIO_W-1:0]  out_priority,
  input logic [prst_pkg::IP_W-1:0]    out_src_address,
  input logic [prst_pkg::IP_W-1:0]    out_src_netmask,
  input logic [prst_pkg::IP_W-1:0]    out_dst_address,
  input logic [prst_pkg::IP_W-1:0]    out_dst_netmask,
  input logic [prst_pkg::OPT_W-1:0]   out_options,
  input logic [prst_pkg::COUNT_W-1:0] rule_count
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_valid) && $stable(out_id) && $stable(rule_count))
    else $error("response changed while stalled");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_status == prst_pkg::STAT_OK)
    else $error("entry valid with non-ok status");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_id == '0 && out_priority == '0 &&
      out_src_address == '0 && out_src_netmask == '0 &&
      out_dst_address == '0 && out_dst_netmask == '0 && out_options == '0)
    else $error("entry fields not cleared");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind priority_sorted_rule_table_core prst_chk u_prst_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_entry_valid (out_rsp.entry_valid),
  .out_id          (out_rsp.out_id),
  .out_priority    (out_rsp.out_priority),
  .out_src_address (out_rsp.out_src_address),
  .out_src_netmask (out_rsp.out_src_netmask),
  .out_dst_address (out_rsp.out_dst_address),
  .out_dst_netmask (out_rsp.out_dst_netmask),
  .out_options     (out_rsp.out_options),
  .rule_count      (out_rsp.rule_count)
);

### tb/priority_sorted_rule_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_rule_table_core_tb
// Self-checking bench for the priority-sorted rule table. Requests go in
// through a queue-fed driver, and a shadow table works out each response.
// A directed opening covers empty, miss, tie and extreme-value cases.
// Random fill, churn and drain runs follow, to reach a full table, with
// varying backpressure on both channels.
// ----------------------------------------------------------------------------
module priority_sorted_rule_table_core_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int ID_POOL_N   = 32;
  localparam int ID_W        = prst_pkg::ID_W;
  localparam int PRIO_W      = prst_pkg::PRIO_W;
  localparam int IP_W        = prst_pkg::IP_W;
  localparam int OPT_W       = prst_pkg::OPT_W;
  localparam int SLOT_W      = prst_pkg::SLOT_W;
  localparam int COUNT_W     = prst_pkg::COUNT_W;

  typedef struct packed {
    prst_pkg::kind_t   kind;
    logic [ID_W-1:0]   target_id;
    prst_pkg::rule_t   rule;
    logic [SLOT_W-1:0] read_slot;
  } rule_req_t;

  typedef struct packed {
    prst_pkg::status_t  status;
    logic               entry_valid;
    prst_pkg::rule_t    rule;
    logic [COUNT_W-1:0] count;
  } rule_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  prst_req_if req_if ();
  prst_rsp_if rsp_if ();

  priority_sorted_rule_table_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always #4 clk = ~clk;

  rule_req_t       pending_requests[$];
  rule_rsp_t       expected_responses[$];
  rule_req_t       offered_req;
  prst_pkg::rule_t rule_store[TABLE_DEPTH];
  int              rule_total;
  int              peak_rules;
  int              kind_tally[4];
  int              status_tally[4];
  int              accepted_count;
  int              fail_count;
  int              sender_idle_pct;
  int              recv_idle_pct;
  logic            hold_rsp;
  logic [ID_W-1:0] id_pool[ID_POOL_N];

  // shadow of the table: applies one request and returns its response
  function automatic rule_rsp_t apply_to_table(rule_req_t r);
    rule_rsp_t res;
    int        pos;
    res = '0;
    pos = -1;
    kind_tally[r.kind]++;
    for (int i = 0; i < rule_total; i++)
      if (pos < 0 && rule_store[i].id == r.target_id) pos = i;
    case (r.kind)
      prst_pkg::KIND_INSERT: begin
        if (rule_total == TABLE_DEPTH) begin
          res.status = prst_pkg::STAT_FULL;
        end else begin
          pos = 0;
          while (pos < rule_total && rule_store[pos].prio <= r.rule.prio) pos++;
          for (int i = rule_total; i > pos; i--) rule_store[i] = rule_store[i-1];
          rule_store[pos] = r.rule;
          rule_total++;
        end
      end
      prst_pkg::KIND_DELETE: begin
        if (pos < 0) begin
          res.status = prst_pkg::STAT_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < rule_total; i++) rule_store[i] = rule_store[i+1];
          rule_total--;
        end
      end
      prst_pkg::KIND_UPDATE: begin
        if (pos < 0) res.status = prst_pkg::STAT_NOT_FOUND;
        else rule_store[pos] = r.rule;
      end
      default: begin
        if (r.read_slot >= rule_total) begin
          res.status = prst_pkg::STAT_EMPTY;
        end else begin
          res.entry_valid = 1'b1;
          res.rule        = rule_store[r.read_slot];
        end
      end
    endcase
    if (rule_total > peak_rules) peak_rules = rule_total;
    status_tally[res.status]++;
    res.count = COUNT_W'(rule_total);
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_responses = {expected_responses, apply_to_table(offered_req)};
        accepted_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_req = pending_requests.pop_front();
          req_if.kind          <= offered_req.kind;
          req_if.target_id     <= offered_req.target_id;
          req_if.new_id        <= offered_req.rule.id;
          req_if.rule_priority <= offered_req.rule.prio;
          req_if.src_address   <= offered_req.rule.src_addr;
          req_if.src_netmask   <= offered_req.rule.src_mask;
          req_if.dst_address   <= offered_req.rule.dst_addr;
          req_if.dst_netmask   <= offered_req.rule.dst_mask;
          req_if.rule_options  <= offered_req.rule.options;
          req_if.read_slot     <= offered_req.read_slot;
          req_if.valid         <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_response();
    rule_rsp_t want;
    if (expected_responses.size() == 0) begin
      $error("response with no request outstanding");
      fail_count++;
    end else begin
      want = expected_responses.pop_front();
      compare_field("status", want.status, rsp_if.status);
      compare_field("entry_valid", want.entry_valid, rsp_if.entry_valid);
      compare_field("out_id", want.rule.id, rsp_if.out_id);
      compare_field("out_priority", want.rule.prio, rsp_if.out_priority);
      compare_field("out_src_address", want.rule.src_addr, rsp_if.out_src_address);
      compare_field("out_src_netmask", want.rule.src_mask, rsp_if.out_src_netmask);
      compare_field("out_dst_address", want.rule.dst_addr, rsp_if.out_dst_address);
      compare_field("out_dst_netmask", want.rule.dst_mask, rsp_if.out_dst_netmask);
      compare_field("out_options", want.rule.options, rsp_if.out_options);
      compare_field("rule_count", want.count, rsp_if.rule_count);
    end
  endtask

  // response monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_response();
      rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long response stall so that the table backs up onto the request side
  initial begin
    hold_rsp = 1'b0;
    do @(negedge clk); while (accepted_count < 400);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] pick_bits();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(ID_POOL_N-1)];
    return ID_W'($urandom);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return PRIO_W'($urandom_range(7));
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return PRIO_W'($urandom);
  endfunction

  function automatic prst_pkg::rule_t random_rule();
    prst_pkg::rule_t r;
    r.id       = pick_id();
    r.prio     = pick_prio();
    r.src_addr = IP_W'(pick_bits());
    r.src_mask = IP_W'(pick_bits());
    r.dst_addr = IP_W'(pick_bits());
    r.dst_mask = IP_W'(pick_bits());
    r.options  = OPT_W'(pick_bits());
    return r;
  endfunction

  task automatic add_request(prst_pkg::kind_t k, logic [ID_W-1:0] target,
                             prst_pkg::rule_t rule, logic [SLOT_W-1:0] slot);
    rule_req_t r;
    r.kind      = k;
    r.target_id = target;
    r.rule      = rule;
    r.read_slot = slot;
    pending_requests = {pending_requests, r};
  endtask

  // runs of fill, churn, drain and noise traffic
  task automatic queue_random(int items);
    int              left;
    int              run_len;
    int              run_kind;
    int              ins_pct;
    int              del_pct;
    int              upd_pct;
    int              roll;
    prst_pkg::kind_t k;
    left = items;
    while (left > 0) begin
      run_kind = $urandom_range(9);
      run_len  = $urandom_range(110, 30);
      if (run_len > left) run_len = left;
      case (run_kind)
        0, 1, 2, 3: begin ins_pct = 85; del_pct = 5;  upd_pct = 5;  end
        4, 5, 6:    begin ins_pct = 25; del_pct = 25; upd_pct = 25; end
        7, 8:       begin ins_pct = 10; del_pct = 60; upd_pct = 10; end
        default:    begin ins_pct = 25; del_pct = 25; upd_pct = 25; end
      endcase
      for (int i = 0; i < run_len; i++) begin
        roll = $urandom_range(99);
        if (roll < ins_pct) k = prst_pkg::KIND_INSERT;
        else if (roll < ins_pct + del_pct) k = prst_pkg::KIND_DELETE;
        else if (roll < ins_pct + del_pct + upd_pct) k = prst_pkg::KIND_UPDATE;
        else k = prst_pkg::KIND_READ;
        add_request(k, (run_kind == 9) ? ID_W'($urandom) : pick_id(), random_rule(),
                    SLOT_W'($urandom));
      end
      left -= run_len;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_if.valid || expected_responses.size() != 0);
  endtask

  initial begin
    prst_pkg::rule_t r;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.kind          = prst_pkg::KIND_READ;
    req_if.target_id     = '0;
    req_if.new_id        = '0;
    req_if.rule_priority = '0;
    req_if.src_address   = '0;
    req_if.src_netmask   = '0;
    req_if.dst_address   = '0;
    req_if.dst_netmask   = '0;
    req_if.rule_options  = '0;
    req_if.read_slot     = '0;
    rsp_if.ready         = 1'b0;
    rule_total           = 0;
    peak_rules           = 0;
    accepted_count       = 0;
    fail_count           = 0;
    kind_tally           = '{default: 0};
    status_tally         = '{default: 0};
    sender_idle_pct      = 27;
    recv_idle_pct        = 72;
    id_pool[0]           = '0;
    id_pool[1]           = '1;
    for (int i = 2; i < ID_POOL_N; i++) id_pool[i] = ID_W'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: read, delete and update all miss
    add_request(prst_pkg::KIND_READ, '0, '0, '0);
    add_request(prst_pkg::KIND_DELETE, 14'd5, '0, '0);
    add_request(prst_pkg::KIND_UPDATE, '1, '1, '0);
    // extreme rules, then an equal-priority pair with a duplicate id
    add_request(prst_pkg::KIND_INSERT, '0, '1, '1);
    add_request(prst_pkg::KIND_INSERT, '1, '0, '0);
    r = random_rule(); r.id = 14'd100; r.prio = 16'h8000;
    add_request(prst_pkg::KIND_INSERT, '0, r, '0);
    r = random_rule(); r.id = 14'd100; r.prio = 16'h8000;
    add_request(prst_pkg::KIND_INSERT, '0, r, '0);
    for (int s = 0; s < 5; s++) add_request(prst_pkg::KIND_READ, '0, '0, SLOT_W'(s));
    // update hits the first duplicate only and does not re-sort
    r = random_rule(); r.id = 14'd200; r.prio = 16'd1;
    add_request(prst_pkg::KIND_UPDATE, 14'd100, r, '0);
    add_request(prst_pkg::KIND_READ, '0, '0, 6'd1);
    add_request(prst_pkg::KIND_READ, '0, '0, 6'd2);
    add_request(prst_pkg::KIND_DELETE, 14'd100, '0, '0);
    add_request(prst_pkg::KIND_DELETE, '1, '0, '0);
    add_request(prst_pkg::KIND_DELETE, '0, '0, '0);
    add_request(prst_pkg::KIND_READ, '0, '0, '1);
    add_request(prst_pkg::KIND_READ, '0, '0, '0);
    wait_drained();

    queue_random(650);
    wait_drained();
    sender_idle_pct = 72;
    recv_idle_pct   = 27;
    queue_random(650);
    wait_drained();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    queue_random(630);
    wait_drained();
    repeat (80) @(posedge clk);

    $display("Ran %0d requests: %0d insert, %0d delete, %0d update, %0d read; peak %0d rules",
             accepted_count, kind_tally[prst_pkg::KIND_INSERT],
             kind_tally[prst_pkg::KIND_DELETE], kind_tally[prst_pkg::KIND_UPDATE],
             kind_tally[prst_pkg::KIND_READ], peak_rules);
    $display("Statuses: %0d ok, %0d id miss, %0d table full, %0d empty slot",
             status_tally[prst_pkg::STAT_OK], status_tally[prst_pkg::STAT_NOT_FOUND],
             status_tally[prst_pkg::STAT_FULL], status_tally[prst_pkg::STAT_EMPTY]);
    if (fail_count == 0 && expected_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
